[src/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// ccc_pkg: shared constants and types for the circle pair collision pipeline
// Widths of coordinates, squared distance and normal fraction.
// ----------------------------------------------------------------------------
package ccc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int TAG_WIDTH   = 16;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;          // |A - B|
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH + 1;        // dx^2 + dy^2
    localparam int ROOT_WIDTH  = (SQ_WIDTH + 1) / 2;       // isqrt result
    localparam int NORM_FRAC   = 30;
    localparam int NORM_WIDTH  = 32;
    localparam int QUO_WIDTH   = NORM_FRAC + 1;            // quotient <= 2^30
    localparam int REM_WIDTH   = ROOT_WIDTH + 1;

    // Per-item data carried alongside the root and divider stages.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic                          neg_x;
        logic                          neg_y;
        logic [MAG_WIDTH-1:0]          mx;
        logic [MAG_WIDTH-1:0]          my;
        logic [RAD_WIDTH-1:0]          ra;
        logic [COORD_WIDTH-1:0]        rsum;
        logic [TAG_WIDTH-1:0]          tag_a;
        logic [TAG_WIDTH-1:0]          tag_b;
    } ccc_side_t;

endpackage

[src/ccc_sqrt.sv]
// ----------------------------------------------------------------------------
// ccc_sqrt: pipelined integer square root
// One result bit per stage, restoring method, item enters every cycle.
// ----------------------------------------------------------------------------
module ccc_sqrt
    import ccc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [SQ_WIDTH-1:0]   radicand,
    input  ccc_side_t             in_side,
    output logic                  out_valid,
    output logic [ROOT_WIDTH-1:0] root,
    output ccc_side_t             out_side
);

    localparam int N = ROOT_WIDTH;
    localparam int PW = 2 * N;

    logic [N:0]              valid_reg;
    logic [PW-1:0]           val_reg  [N+1];   // remaining radicand bits
    logic [N+1:0]            rem_reg  [N+1];
    logic [N-1:0]            res_reg  [N+1];
    ccc_side_t               side_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg[0]  <= PW'(radicand);
        rem_reg[0]  <= '0;
        res_reg[0]  <= '0;
        side_reg[0] <= in_side;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N+1:0] trial;
        logic [N+1:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[s][N-1:0], val_reg[s][PW-1:PW-2]};
            trial   = {res_reg[s], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            val_reg[s+1]  <= {val_reg[s][PW-3:0], 2'b00};
            side_reg[s+1] <= side_reg[s];
            if (shifted >= trial)
            begin
                rem_reg[s+1] <= shifted - trial;
                res_reg[s+1] <= {res_reg[s][N-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= shifted;
                res_reg[s+1] <= {res_reg[s][N-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign root      = res_reg[N];
    assign out_side  = side_reg[N];

endmodule

[src/ccc_div.sv]
// ----------------------------------------------------------------------------
// ccc_div: pipelined normal divider
// Both components in parallel: floor(mag * 2^30 / length), one bit per stage.
// ----------------------------------------------------------------------------
module ccc_div
    import ccc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [ROOT_WIDTH-1:0] length,
    input  ccc_side_t             in_side,
    output logic                  out_valid,
    output logic [ROOT_WIDTH-1:0] out_dist,
    output logic [QUO_WIDTH-1:0]  quo_x,
    output logic [QUO_WIDTH-1:0]  quo_y,
    output ccc_side_t             out_side
);

    localparam int N = QUO_WIDTH;

    logic [N:0]            valid_reg;
    logic [REM_WIDTH-1:0]  rx_reg [N+1];
    logic [REM_WIDTH-1:0]  ry_reg [N+1];
    logic [N-1:0]          qx_reg [N+1];
    logic [N-1:0]          qy_reg [N+1];
    logic [ROOT_WIDTH-1:0] d_reg  [N+1];
    ccc_side_t             side_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    // mag <= length always; first stage gets mag unshifted
    always_ff @(posedge clk)
    begin
        rx_reg[0]   <= REM_WIDTH'(in_side.mx);
        ry_reg[0]   <= REM_WIDTH'(in_side.my);
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        d_reg[0]    <= length;
        side_reg[0] <= in_side;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [REM_WIDTH:0] sx;
        logic [REM_WIDTH:0] sy;
        logic [REM_WIDTH:0] dd;
        always_comb
        begin
            dd = (REM_WIDTH+1)'(d_reg[s]);
            if (s == 0)
            begin
                sx = (REM_WIDTH+1)'(rx_reg[s]);
                sy = (REM_WIDTH+1)'(ry_reg[s]);
            end
            else
            begin
                sx = {rx_reg[s], 1'b0};
                sy = {ry_reg[s], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            d_reg[s+1]    <= d_reg[s];
            side_reg[s+1] <= side_reg[s];
            if (sx >= dd)
            begin
                rx_reg[s+1] <= REM_WIDTH'(sx - dd);
                qx_reg[s+1] <= {qx_reg[s][N-2:0], 1'b1};
            end
            else
            begin
                rx_reg[s+1] <= REM_WIDTH'(sx);
                qx_reg[s+1] <= {qx_reg[s][N-2:0], 1'b0};
            end
            if (sy >= dd)
            begin
                ry_reg[s+1] <= REM_WIDTH'(sy - dd);
                qy_reg[s+1] <= {qy_reg[s][N-2:0], 1'b1};
            end
            else
            begin
                ry_reg[s+1] <= REM_WIDTH'(sy);
                qy_reg[s+1] <= {qy_reg[s][N-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_dist  = d_reg[N];
    assign quo_x     = qx_reg[N];
    assign quo_y     = qy_reg[N];
    assign out_side  = side_reg[N];

endmodule

[src/circle_circle_collision.sv]
// ----------------------------------------------------------------------------
// circle_circle_collision: narrow-phase circle pair test
// Order: difference, squares, sum, square root, divider, then hit test, offset and contact point.
// Throughput: one word per cycle; busy is held low, start is taken each cycle.
// The square root and divider are fully unrolled one-bit-per-stage pipelines.
// Reset (rst_n, async low) clears every valid bit; payload is not reset.
// The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
module circle_circle_collision
    import ccc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] pos_a_x,
    input  logic signed [COORD_WIDTH-1:0] pos_a_y,
    input  logic signed [COORD_WIDTH-1:0] pos_b_x,
    input  logic signed [COORD_WIDTH-1:0] pos_b_y,
    input  logic [RAD_WIDTH-1:0]          radius_a,
    input  logic [RAD_WIDTH-1:0]          radius_b,
    input  logic [TAG_WIDTH-1:0]          entity_a_id,
    input  logic [TAG_WIDTH-1:0]          entity_b_id,
    output logic                          done,
    output logic                          colliding,
    output logic [COORD_WIDTH-1:0]        depth,
    output logic signed [NORM_WIDTH-1:0]  normal_x,
    output logic signed [NORM_WIDTH-1:0]  normal_y,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic [TAG_WIDTH-1:0]          first_entity,
    output logic [TAG_WIDTH-1:0]          second_entity
);

    localparam int PROD_W = QUO_WIDTH + RAD_WIDTH;   // |n| * ra
    localparam int PT_W   = COORD_WIDTH + 2;

    assign busy = 1'b0;

    // ---- stage 1: difference and magnitudes ----
    logic                 s1_valid_reg;
    ccc_side_t            s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    logic signed [MAG_WIDTH-1:0] dx_c;
    logic signed [MAG_WIDTH-1:0] dy_c;
    always_comb
    begin
        dx_c = MAG_WIDTH'(pos_a_x) - MAG_WIDTH'(pos_b_x);
        dy_c = MAG_WIDTH'(pos_a_y) - MAG_WIDTH'(pos_b_y);
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg.ax    <= pos_a_x;
        s1_side_reg.ay    <= pos_a_y;
        s1_side_reg.neg_x <= dx_c[MAG_WIDTH-1];
        s1_side_reg.neg_y <= dy_c[MAG_WIDTH-1];
        s1_side_reg.mx    <= dx_c[MAG_WIDTH-1] ? MAG_WIDTH'(-dx_c) : MAG_WIDTH'(dx_c);
        s1_side_reg.my    <= dy_c[MAG_WIDTH-1] ? MAG_WIDTH'(-dy_c) : MAG_WIDTH'(dy_c);
        s1_side_reg.ra    <= radius_a;
        s1_side_reg.rsum  <= COORD_WIDTH'(radius_a) + COORD_WIDTH'(radius_b);
        s1_side_reg.tag_a <= entity_a_id;
        s1_side_reg.tag_b <= entity_b_id;
    end

    // ---- stage 2: squares ----
    logic                      s2_valid_reg;
    ccc_side_t                 s2_side_reg;
    logic [2*MAG_WIDTH-1:0]    sqx_reg;
    logic [2*MAG_WIDTH-1:0]    sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg     <= s1_side_reg.mx * s1_side_reg.mx;
        sqy_reg     <= s1_side_reg.my * s1_side_reg.my;
        s2_side_reg <= s1_side_reg;
    end

    // ---- stage 3: sum of squares ----
    logic                s3_valid_reg;
    ccc_side_t           s3_side_reg;
    logic [SQ_WIDTH-1:0] sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg      <= SQ_WIDTH'(sqx_reg) + SQ_WIDTH'(sqy_reg);
        s3_side_reg <= s2_side_reg;
    end

    // ---- square root ----
    logic                  rt_valid;
    logic [ROOT_WIDTH-1:0] rt_root;
    ccc_side_t             rt_side;

    ccc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .radicand  (sq_reg),
        .in_side   (s3_side_reg),
        .out_valid (rt_valid),
        .root      (rt_root),
        .out_side  (rt_side)
    );

    // ---- normal divider ----
    logic                  dv_valid;
    logic [ROOT_WIDTH-1:0] dv_dist;
    logic [QUO_WIDTH-1:0]  dv_qx;
    logic [QUO_WIDTH-1:0]  dv_qy;
    ccc_side_t             dv_side;

    ccc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .length    (rt_root),
        .in_side   (rt_side),
        .out_valid (dv_valid),
        .out_dist  (dv_dist),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .out_side  (dv_side)
    );

    // ---- stage c1: hit test, depth, normal magnitude ----
    logic                   c1_valid_reg;
    logic                   c1_hit_reg;
    logic [COORD_WIDTH-1:0] c1_depth_reg;
    logic [QUO_WIDTH-1:0]   c1_nx_reg;
    logic [QUO_WIDTH-1:0]   c1_ny_reg;
    ccc_side_t              c1_side_reg;
    logic                   hit_c;

    assign hit_c = ROOT_WIDTH'(dv_side.rsum) > dv_dist
                   && dv_dist[ROOT_WIDTH-1:COORD_WIDTH] == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg <= dv_valid;
        end
    end

    // miss or zero distance: normal forced to zero
    always_ff @(posedge clk)
    begin
        c1_hit_reg   <= hit_c;
        c1_depth_reg <= hit_c ? dv_side.rsum - COORD_WIDTH'(dv_dist) : '0;
        c1_nx_reg    <= (hit_c && dv_dist != '0) ? dv_qx : '0;
        c1_ny_reg    <= (hit_c && dv_dist != '0) ? dv_qy : '0;
        c1_side_reg  <= dv_side;
    end

    // ---- stage c2: products |n| * ra, scaled by 2^-30 into the offset in c3 ----
    logic                   c2_valid_reg;
    logic                   c2_hit_reg;
    logic [COORD_WIDTH-1:0] c2_depth_reg;
    logic [QUO_WIDTH-1:0]   c2_nx_reg;
    logic [QUO_WIDTH-1:0]   c2_ny_reg;
    logic [PROD_W-1:0]      c2_px_reg;
    logic [PROD_W-1:0]      c2_py_reg;
    ccc_side_t              c2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c2_hit_reg   <= c1_hit_reg;
        c2_depth_reg <= c1_depth_reg;
        c2_nx_reg    <= c1_nx_reg;
        c2_ny_reg    <= c1_ny_reg;
        c2_px_reg    <= PROD_W'(c1_nx_reg) * PROD_W'(c1_side_reg.ra);
        c2_py_reg    <= PROD_W'(c1_ny_reg) * PROD_W'(c1_side_reg.ra);
        c2_side_reg  <= c1_side_reg;
    end

    // ---- stage c3: signed normal, contact point with saturation ----
    localparam logic signed [PT_W-1:0] PT_MAX = PT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [PT_W-1:0] PT_MIN = -PT_MAX - PT_W'(1);

    logic signed [PT_W-1:0] offx_c;
    logic signed [PT_W-1:0] offy_c;
    logic signed [PT_W-1:0] sumx_c;
    logic signed [PT_W-1:0] sumy_c;
    logic signed [COORD_WIDTH-1:0] satx_c;
    logic signed [COORD_WIDTH-1:0] saty_c;

    always_comb
    begin
        offx_c = PT_W'(c2_px_reg >> NORM_FRAC);
        offy_c = PT_W'(c2_py_reg >> NORM_FRAC);
        sumx_c = c2_side_reg.neg_x ? PT_W'(c2_side_reg.ax) - offx_c
                                   : PT_W'(c2_side_reg.ax) + offx_c;
        sumy_c = c2_side_reg.neg_y ? PT_W'(c2_side_reg.ay) - offy_c
                                   : PT_W'(c2_side_reg.ay) + offy_c;
        if (sumx_c > PT_MAX)
            satx_c = PT_MAX[COORD_WIDTH-1:0];
        else if (sumx_c < PT_MIN)
            satx_c = PT_MIN[COORD_WIDTH-1:0];
        else
            satx_c = sumx_c[COORD_WIDTH-1:0];
        if (sumy_c > PT_MAX)
            saty_c = PT_MAX[COORD_WIDTH-1:0];
        else if (sumy_c < PT_MIN)
            saty_c = PT_MIN[COORD_WIDTH-1:0];
        else
            saty_c = sumy_c[COORD_WIDTH-1:0];
    end

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        colliding     <= c2_hit_reg;
        depth         <= c2_depth_reg;
        normal_x      <= c2_side_reg.neg_x ? -NORM_WIDTH'(c2_nx_reg) : NORM_WIDTH'(c2_nx_reg);
        normal_y      <= c2_side_reg.neg_y ? -NORM_WIDTH'(c2_ny_reg) : NORM_WIDTH'(c2_ny_reg);
        point_x       <= c2_hit_reg ? satx_c : '0;
        point_y       <= c2_hit_reg ? saty_c : '0;
        first_entity  <= c2_side_reg.tag_a;
        second_entity <= c2_side_reg.tag_b;
    end

    assign done = done_reg;

    // ---- checks ----
    a_busy_low: assert property (@(posedge clk) busy == 1'b0)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid_reg |=> done)
        else $error("result lost");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !colliding) |-> (depth == '0 && point_x == '0 && normal_x == '0))
        else $error("miss not zeroed");
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        c1_valid_reg |-> (c1_nx_reg <= QUO_WIDTH'(1 << NORM_FRAC)))
        else $error("normal above one");

endmodule

[dv/circle_circle_collision_tb.sv]
// ----------------------------------------------------------------------------
// circle_circle_collision_tb: self-checking bench for the circle pair test
// Streams directed and random circle pairs with random start gaps. Each
// accepted word goes through a local contact predictor, and every done word
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module circle_circle_collision_tb
    import ccc_pkg::*;
();

    localparam int TAIL_CYCLES  = 120;      // a bit over the pipeline latency
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PAIRS = 1050;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
        logic [RAD_WIDTH-1:0]          ra, rb;
        logic [TAG_WIDTH-1:0]          ta, tb;
    } pair_t;

    typedef struct {
        logic                          hit;
        logic [COORD_WIDTH-1:0]        depth;
        logic signed [NORM_WIDTH-1:0]  nx, ny;
        logic signed [COORD_WIDTH-1:0] px, py;
        logic [TAG_WIDTH-1:0]          ta, tb;
    } contact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_WIDTH-1:0] pos_a_x = '0, pos_a_y = '0, pos_b_x = '0, pos_b_y = '0;
    logic [RAD_WIDTH-1:0] radius_a = '0, radius_b = '0;
    logic [TAG_WIDTH-1:0] entity_a_id = '0, entity_b_id = '0;
    logic done, colliding;
    logic [COORD_WIDTH-1:0] depth;
    logic signed [NORM_WIDTH-1:0] normal_x, normal_y;
    logic signed [COORD_WIDTH-1:0] point_x, point_y;
    logic [TAG_WIDTH-1:0] first_entity, second_entity;

    pair_t    pair_queue[$];        // words waiting to be driven
    contact_t contact_queue[$];     // predictions waiting for done
    int       mismatches = 0;
    int       pairs_taken = 0;
    int       hits_seen = 0;
    int       words_checked = 0;
    int       cycles = 0;
    int       gap_left = 0;
    bit       no_idle = 1'b0;       // stretches with start held every cycle

    circle_circle_collision uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
        .radius_a(radius_a), .radius_b(radius_b),
        .entity_a_id(entity_a_id), .entity_b_id(entity_b_id),
        .done(done), .colliding(colliding), .depth(depth),
        .normal_x(normal_x), .normal_y(normal_y),
        .point_x(point_x), .point_y(point_y),
        .first_entity(first_entity), .second_entity(second_entity)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Contact point on one axis: a +/- floor(n * ra / 2^30), clamped.
    function automatic logic signed [COORD_WIDTH-1:0] contact_axis(
        longint a, longint nmag, bit neg, longint ra);
        longint off;
        longint p;
        off = (nmag * ra) >>> NORM_FRAC;
        p = neg ? a - off : a + off;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[COORD_WIDTH-1:0];
    endfunction

    function automatic contact_t predict_contact(pair_t p);
        contact_t r;
        longint dx, dy, mx, my, dist_root, rsum, nmx, nmy;
        logic [67:0] sq, cand;
        dx = longint'(p.ax) - longint'(p.bx);
        dy = longint'(p.ay) - longint'(p.by);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sq = 68'(mx) * 68'(mx) + 68'(my) * 68'(my);
        // exact floor square root, one bit at a time; root stays below 2^33
        dist_root = 0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = 68'(dist_root) | (68'd1 << b);
            if (cand * cand <= sq)
                dist_root = longint'(cand);
        end
        rsum = longint'(p.ra) + longint'(p.rb);
        r = '{default: '0};
        r.ta = p.ta;
        r.tb = p.tb;
        r.hit = dist_root < rsum;
        if (r.hit)
        begin
            r.depth = COORD_WIDTH'(rsum - dist_root);
            nmx = 0;
            nmy = 0;
            // the root is at least each magnitude, so quotients never pass 2^30
            if (dist_root != 0)
            begin
                nmx = (mx << NORM_FRAC) / dist_root;
                nmy = (my << NORM_FRAC) / dist_root;
            end
            r.nx = NORM_WIDTH'(dx < 0 ? -nmx : nmx);
            r.ny = NORM_WIDTH'(dy < 0 ? -nmy : nmy);
            r.px = contact_axis(longint'(p.ax), nmx, dx < 0, longint'(p.ra));
            r.py = contact_axis(longint'(p.ay), nmy, dy < 0, longint'(p.ra));
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 63) == 0)
            no_idle = !no_idle;
        if (no_idle || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: one nonblocking write per DUT input per edge.
    always @(posedge clk)
    begin
        pair_t p;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                contact_queue.push_back(predict_contact('{pos_a_x, pos_a_y,
                    pos_b_x, pos_b_y, radius_a, radius_b, entity_a_id, entity_b_id}));
                pairs_taken++;
            end
            if (start && busy)
                start <= 1'b1;              // hold the word until taken
            else if (gap_left > 0 || pair_queue.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                p = pair_queue.pop_front();
                pos_a_x     <= p.ax;
                pos_a_y     <= p.ay;
                pos_b_x     <= p.bx;
                pos_b_y     <= p.by;
                radius_a    <= p.ra;
                radius_b    <= p.rb;
                entity_a_id <= p.ta;
                entity_b_id <= p.tb;
                start       <= 1'b1;
                gap_left    = pick_gap();
            end
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v, int idx);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: %s expected %0h got %0h", idx, name, exp_v, act_v);
        end
    endtask

    // Monitor: results cannot be held off, so sample every done.
    always @(posedge clk)
    begin
        contact_t e;
        cycles++;
        if (rst_n && done)
        begin
            if (contact_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected done word, nothing pending");
            end
            else
            begin
                e = contact_queue.pop_front();
                check_field("colliding", e.hit, colliding, words_checked);
                check_field("depth", e.depth, depth, words_checked);
                check_field("normal_x", e.nx, normal_x, words_checked);
                check_field("normal_y", e.ny, normal_y, words_checked);
                check_field("point_x", e.px, point_x, words_checked);
                check_field("point_y", e.py, point_y, words_checked);
                check_field("first_entity", e.ta, first_entity, words_checked);
                check_field("second_entity", e.tb, second_entity, words_checked);
                if (e.hit)
                    hits_seen++;
                words_checked++;
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic pair_t make_pair(longint ax, longint ay, longint bx, longint by,
                                        longint ra, longint rb);
        pair_t p;
        p.ax = ax[31:0];
        p.ay = ay[31:0];
        p.bx = bx[31:0];
        p.by = by[31:0];
        p.ra = ra[30:0];
        p.rb = rb[30:0];
        p.ta = $urandom;
        p.tb = $urandom;
        return p;
    endfunction

    // Random signed value with only the low 'w' bits of magnitude.
    function automatic longint narrow(int w);
        longint v;
        v = longint'($urandom) & ((64'sd1 << w) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    initial
    begin
        pair_t p;
        longint ax, ay;
        int w;
        // directed: coincident, touching, extremes, saturation
        pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0));                  // all zero
        pair_queue.push_back(make_pair(5, -7, 5, -7, 1, 0));                // coincident
        pair_queue.push_back(make_pair(100, 200, 100, 200, 32'h7fffffff, 32'h7fffffff));
        pair_queue.push_back(make_pair(3 << 16, 0, 0, 0, 1 << 16, 2 << 16)); // touching
        pair_queue.push_back(make_pair(3 << 16, 0, 0, 0, 1 << 16, 2 << 16 + 1));
        pair_queue.push_back(make_pair(0, 3 << 16, 0, 0, 2 << 16, 1 << 16 + 1));
        pair_queue.push_back(make_pair(-3, -4, 0, 0, 3, 3));                // 3-4-5
        pair_queue.push_back(make_pair(-2147483648, -2147483648, 2147483647, 2147483647,
                                       32'h7fffffff, 32'h7fffffff));
        pair_queue.push_back(make_pair(2147483647, 2147483647, -2147483648, -2147483648,
                                       32'h7fffffff, 32'h7fffffff));
        pair_queue.push_back(make_pair(2147483647, 0, 2147483646, 0, 32'h7fffffff, 5));
        pair_queue.push_back(make_pair(-2147483648, 0, -2147483647, 0, 32'h7fffffff, 5));
        pair_queue.push_back(make_pair(0, 2147483600, 0, 2147483500, 32'h40000000, 200));
        pair_queue.push_back(make_pair(0, -2147483600, 0, -2147483500, 32'h40000000, 200));
        pair_queue.push_back(make_pair(1, 1, 0, 0, 1, 1));
        pair_queue.push_back(make_pair(-1, 1, 0, 0, 2, 0));
        pair_queue.push_back(make_pair(7, -9, -2, 4, 32'h7fffffff, 0));
        p = make_pair(10, 10, 0, 0, 100, 100);
        p.ta = 16'hffff;
        p.tb = 16'h0000;
        pair_queue.push_back(p);
        p.ta = 16'h0000;
        p.tb = 16'hffff;
        pair_queue.push_back(p);
        // random: mostly close pairs at a random scale, some full-range noise
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if ($urandom_range(0, 9) < 2)
                p = make_pair(longint'(int'($urandom)), longint'(int'($urandom)),
                              longint'(int'($urandom)), longint'(int'($urandom)),
                              $urandom, $urandom);
            else
            begin
                w = $urandom_range(1, 31);
                if ($urandom_range(0, 7) == 0)
                begin
                    ax = $urandom_range(0, 1) ? 2147483647 - narrow(20) : -2147483648 + narrow(20);
                    ay = longint'(int'($urandom));
                    ax = (ax > 2147483647) ? 2147483647 : ax;
                    ax = (ax < -2147483648) ? -2147483648 : ax;
                end
                else
                begin
                    ax = longint'(int'($urandom));
                    ay = longint'(int'($urandom));
                end
                p = make_pair(ax, ay, ax + narrow(w), ay + narrow(w),
                              longint'($urandom) & ((64'sd1 << $urandom_range(w - 1, 31)) - 1),
                              longint'($urandom) & ((64'sd1 << $urandom_range(0, w)) - 1));
                if ($urandom_range(0, 15) == 0)
                begin
                    p.bx = p.ax;
                    p.by = p.ay;
                end
            end
            pair_queue.push_back(p);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        while (pair_queue.size() != 0 || start)
            @(posedge clk);
        while (contact_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (contact_queue.size() != 0)
            mismatches++;
        $display("%0d pairs sent, %0d results checked, %0d of them colliding",
                 pairs_taken, words_checked, hits_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
